// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: src/rsti_pkg.sv
// ----------------------------------------------------------------------------
// rsti_pkg
// Shared constants and types of the radix string-to-integer parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsti_pkg;

    localparam int SYM_LIMIT       = 16;
    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DIGIT_W         = $clog2(SYM_LIMIT);
    localparam int RADIX_W         = $clog2(SYM_LIMIT + 1);
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int FIFO_DEPTH      = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_SYM_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYM_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE     = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic [SYM_LIMIT-1:0][7:0] symbols;
        logic [RADIX_W-1:0]        radix;
        logic                      base_ok;
    } cfg_t;

    typedef struct packed {
        logic               is_end;
        logic               is_space;
        logic               is_plus;
        logic               is_minus;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
    } class_t;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGNS,
        PH_DIGITS,
        PH_DONE
    } phase_t;

endpackage

// File: src/radix_string_to_integer_top.sv
// ----------------------------------------------------------------------------
// radix_string_to_integer_top
// Byte-stream integer parser with a configurable digit alphabet.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue has room; the multiply-add in the back side is combinational.
// The zero byte is written into the queue, then popped into the result register once the output is free.
// A 4-entry queue lets input continue while a result waits on the output.
// Reset (rst_n low, asynchronous): configuration to 0, queue empty, parse idle, no result.
`timescale 1ns / 1ps

module radix_string_to_integer_top #(
    parameter int MAX_SYMBOLS = rsti_pkg::MAX_SYMBOLS_DEF,
    parameter int VALUE_WIDTH = rsti_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [7:0]                              s_axis_tdata,  // char_code
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,  // value
    output logic                                    m_axis_tuser,  // base_ok
    input  logic                                    cfg_we,
    input  logic [rsti_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [rsti_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

    localparam int OUT_W = ((VALUE_WIDTH + 7) / 8) * 8;

    rsti_pkg::cfg_t             cfg;
    rsti_pkg::class_t           push_item;
    rsti_pkg::class_t           pop_item;
    logic                       push;
    logic                       pop;
    logic                       full;
    logic                       empty;
    logic [VALUE_WIDTH-1:0]     value;

    rsti_cfg #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rsti_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .char_code (s_axis_tdata),
        .cfg       (cfg),
        .fifo_full (full),
        .push      (push),
        .item      (push_item)
    );

    rsti_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    rsti_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .empty     (empty),
        .item      (pop_item),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .value     (value),
        .base_ok   (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_W'(value);

endmodule

// File: src/rsti_cfg.sv
// ----------------------------------------------------------------------------
// rsti_cfg
// Configuration registers and alphabet check: size range, forbidden
// symbols and pairwise duplicates, registered once per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsti_cfg #(
    parameter int MAX_SYMBOLS = rsti_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rsti_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rsti_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output rsti_pkg::cfg_t                      cfg
);

    localparam int RW = rsti_pkg::RADIX_W;

    logic [rsti_pkg::CFG_DATA_W-1:0]            sym_low_reg;
    logic [rsti_pkg::CFG_DATA_W-1:0]            sym_high_reg;
    logic [RW-1:0]                              size_reg;
    logic                                       ok_reg;
    logic                                       ok_next;
    logic [rsti_pkg::SYM_LIMIT-1:0][7:0]        sym;
    logic                                       bad;
    logic                                       size_ok;

    assign sym = {sym_high_reg, sym_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_low_reg  <= '0;
            sym_high_reg <= '0;
            size_reg     <= '0;
            ok_reg       <= 1'b0;
        end
        else
        begin
            ok_reg <= ok_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rsti_pkg::REG_SYM_LOW:  sym_low_reg  <= cfg_wdata;
                    rsti_pkg::REG_SYM_HIGH: sym_high_reg <= cfg_wdata;
                    rsti_pkg::REG_SIZE:     size_reg     <= cfg_wdata[RW-1:0];
                    default:                ;
                endcase
            end
        end
    end

    always_comb
    begin
        bad = 1'b0;
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            if (RW'(i) < size_reg)
            begin
                if (sym[i] == rsti_pkg::CH_NUL || sym[i] == rsti_pkg::CH_PLUS ||
                    sym[i] == rsti_pkg::CH_MINUS)
                begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++)
                begin
                    if (RW'(j) < size_reg && sym[j] == sym[i])
                    begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    assign size_ok = (size_reg >= RW'(2)) && (size_reg <= RW'(MAX_SYMBOLS));
    assign ok_next = size_ok && !bad;

    assign cfg.symbols = sym;
    assign cfg.radix   = (size_reg > RW'(MAX_SYMBOLS)) ? RW'(MAX_SYMBOLS) : size_reg;
    assign cfg.base_ok = ok_reg;

endmodule

// File: src/rsti_front.sv
// ----------------------------------------------------------------------------
// rsti_front
// Input side: accept a byte while the queue has room and classify it as
// terminator, white space, sign or alphabet digit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsti_front #(
    parameter int MAX_SYMBOLS = rsti_pkg::MAX_SYMBOLS_DEF
) (
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    input  rsti_pkg::cfg_t     cfg,
    input  logic               fifo_full,
    output logic               push,
    output rsti_pkg::class_t   item
);

    localparam int RW = rsti_pkg::RADIX_W;
    localparam int DW = rsti_pkg::DIGIT_W;

    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full;

    always_comb
    begin
        item.is_end   = (char_code == rsti_pkg::CH_NUL);
        item.is_space = ((char_code >= rsti_pkg::CH_TAB) && (char_code <= rsti_pkg::CH_CR)) ||
                        (char_code == rsti_pkg::CH_SPACE);
        item.is_plus  = (char_code == rsti_pkg::CH_PLUS);
        item.is_minus = (char_code == rsti_pkg::CH_MINUS);
        item.is_digit = 1'b0;
        item.digit    = '0;
        // lowest matching position wins
        for (int j = MAX_SYMBOLS - 1; j >= 0; j--)
        begin
            if (RW'(j) < cfg.radix && cfg.symbols[j] == char_code)
            begin
                item.is_digit = 1'b1;
                item.digit    = DW'(j);
            end
        end
    end

endmodule

// File: src/rsti_fifo.sv
// ----------------------------------------------------------------------------
// rsti_fifo
// Short queue of classified items between the front and back sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rsti_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rsti_pkg::class_t   push_item,
    output logic               full,
    input  logic               pop,
    output rsti_pkg::class_t   pop_item,
    output logic               empty
);

    localparam int DEPTH = rsti_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rsti_pkg::class_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_IMPL(a_fifo_no_overflow, clk, rst_n, push, !full)
    `ASSERT_NEXT(a_fifo_pop_shrinks, clk, rst_n, pop && !push, count_reg == $past(count_reg) - CNT_W'(1))

endmodule

// File: src/rsti_back.sv
// ----------------------------------------------------------------------------
// rsti_back
// Parse sequencer: tracks the phase and sign, runs one multiply-add per
// digit until the number ends and loads the result register at the terminator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rsti_back #(
    parameter int VALUE_WIDTH = rsti_pkg::VALUE_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rsti_pkg::cfg_t          cfg,
    input  logic                    empty,
    input  rsti_pkg::class_t        item,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [VALUE_WIDTH-1:0]  value,
    output logic                    base_ok
);

    localparam int VW = VALUE_WIDTH;

    rsti_pkg::phase_t   phase_reg;
    rsti_pkg::phase_t   phase_next;
    logic               neg_reg;
    logic               neg_next;
    logic [VW-1:0]      acc_reg;
    logic [VW-1:0]      acc_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VW-1:0]      out_value_reg;
    logic [VW-1:0]      out_value_next;
    logic               out_ok_reg;
    logic               out_ok_next;
    logic [VW-1:0]      mac;
    logic [VW-1:0]      signed_val;
    logic               is_sign;
    logic               take_end;

    assign pop      = !empty && (!item.is_end || !out_valid_reg || out_ready);
    assign take_end = pop && item.is_end;
    assign is_sign  = item.is_plus || item.is_minus;

    assign mac        = acc_reg * VW'(cfg.radix) + VW'(item.digit);
    assign signed_val = neg_reg ? (VW'(0) - acc_reg) : acc_reg;

    always_comb
    begin
        phase_next = phase_reg;
        if (pop)
        begin
            priority if (item.is_end)
                phase_next = rsti_pkg::PH_SPACE;
            else if (phase_reg == rsti_pkg::PH_DONE)
                phase_next = rsti_pkg::PH_DONE;
            else if (phase_reg == rsti_pkg::PH_SPACE && item.is_space)
                phase_next = rsti_pkg::PH_SPACE;
            else if ((phase_reg == rsti_pkg::PH_SPACE || phase_reg == rsti_pkg::PH_SIGNS) &&
                     is_sign)
                phase_next = rsti_pkg::PH_SIGNS;
            else if (item.is_digit)
                phase_next = rsti_pkg::PH_DIGITS;
            else
                phase_next = rsti_pkg::PH_DONE;
        end
    end

    always_comb
    begin
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_ok_next    = out_ok_reg;
        if (pop)
        begin
            priority if (item.is_end)
            begin
                neg_next       = 1'b0;
                acc_next       = '0;
                out_valid_next = 1'b1;
                out_value_next = cfg.base_ok ? signed_val : '0;
                out_ok_next    = cfg.base_ok;
            end
            else if (phase_reg == rsti_pkg::PH_DONE)
            begin
                acc_next = acc_reg;
            end
            else if (phase_reg == rsti_pkg::PH_SPACE && item.is_space)
            begin
                acc_next = acc_reg;
            end
            else if ((phase_reg == rsti_pkg::PH_SPACE || phase_reg == rsti_pkg::PH_SIGNS) &&
                     is_sign)
            begin
                neg_next = neg_reg ^ item.is_minus;
            end
            else if (item.is_digit)
            begin
                acc_next = mac;
            end
            else
            begin
                acc_next = acc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rsti_pkg::PH_SPACE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_ok_reg    <= out_ok_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;
    assign base_ok   = out_ok_reg;

    `ASSERT_NEXT(a_back_end_clears, clk, rst_n, take_end, out_valid_reg && phase_reg == rsti_pkg::PH_SPACE && acc_reg == '0 && !neg_reg)
    `ASSERT_NEXT(a_back_done_holds, clk, rst_n, pop && !item.is_end && phase_reg == rsti_pkg::PH_DONE, $stable(acc_reg) && phase_reg == rsti_pkg::PH_DONE)

endmodule
